// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define SREC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SREC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/srec_pkg.sv
// types, constants and microcode table of the s-record s3 encoder
`timescale 1ns / 1ps

package srec_pkg;

  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_LAST = 2'd1;

  localparam int ADDR_W = 32;
  localparam int PC_W   = 6;

  // record length byte is address (4) + checksum (1) + data count
  localparam logic [7:0] LEN_BASE = 8'd5;

  localparam logic [PC_W-1:0] PC_HDR    = 6'd0;
  localparam logic [PC_W-1:0] PC_REC    = 6'd11;
  localparam logic [PC_W-1:0] PC_DATA_H = 6'd23;
  localparam logic [PC_W-1:0] PC_END    = 6'd28;

  typedef enum logic [2:0] {
    JMP_NEXT    = 3'd0,
    JMP_HDR_END = 3'd1,
    JMP_DATA    = 3'd2,
    JMP_REC_END = 3'd3,
    JMP_DONE    = 3'd4
  } jmp_t;

  typedef enum logic [2:0] {
    SRC_LIT    = 3'd0,
    SRC_LEN_H  = 3'd1,
    SRC_LEN_L  = 3'd2,
    SRC_ADDR   = 3'd3,
    SRC_DATA_H = 3'd4,
    SRC_DATA_L = 3'd5,
    SRC_SUM_H  = 3'd6,
    SRC_SUM_L  = 3'd7
  } src_t;

  typedef struct packed {
    jmp_t       jmp;
    src_t       src;
    logic [2:0] nib;   // address nibble, most significant first
    logic [6:0] ch;
  } uword_t;

  function automatic uword_t uw_lit(input logic [6:0] c, input jmp_t j);
    uword_t w;
    w.jmp = j;
    w.src = SRC_LIT;
    w.nib = 3'd0;
    w.ch  = c;
    return w;
  endfunction

  function automatic uword_t uw_hex(input src_t s, input logic [2:0] n, input jmp_t j);
    uword_t w;
    w.jmp = j;
    w.src = s;
    w.nib = n;
    w.ch  = 7'd0;
    return w;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] c;
    if (n < 4'd10) begin
      c = 7'("0") + {3'd0, n};
    end else begin
      c = 7'("A") + {3'd0, n} - 7'd10;
    end
    return c;
  endfunction

  // program: header, data record, end record
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      6'd0:  w = uw_lit(7'("S"), JMP_NEXT);
      6'd1:  w = uw_lit(7'("0"), JMP_NEXT);
      6'd2:  w = uw_lit(7'("0"), JMP_NEXT);
      6'd3:  w = uw_lit(7'("3"), JMP_NEXT);
      6'd4:  w = uw_lit(7'("0"), JMP_NEXT);
      6'd5:  w = uw_lit(7'("0"), JMP_NEXT);
      6'd6:  w = uw_lit(7'("0"), JMP_NEXT);
      6'd7:  w = uw_lit(7'("0"), JMP_NEXT);
      6'd8:  w = uw_lit(7'("F"), JMP_NEXT);
      6'd9:  w = uw_lit(7'("C"), JMP_NEXT);
      6'd10: w = uw_lit(7'h0A, JMP_HDR_END);
      6'd11: w = uw_lit(7'("S"), JMP_NEXT);
      6'd12: w = uw_lit(7'("3"), JMP_NEXT);
      6'd13: w = uw_hex(SRC_LEN_H, 3'd0, JMP_NEXT);
      6'd14: w = uw_hex(SRC_LEN_L, 3'd0, JMP_NEXT);
      6'd15: w = uw_hex(SRC_ADDR, 3'd0, JMP_NEXT);
      6'd16: w = uw_hex(SRC_ADDR, 3'd1, JMP_NEXT);
      6'd17: w = uw_hex(SRC_ADDR, 3'd2, JMP_NEXT);
      6'd18: w = uw_hex(SRC_ADDR, 3'd3, JMP_NEXT);
      6'd19: w = uw_hex(SRC_ADDR, 3'd4, JMP_NEXT);
      6'd20: w = uw_hex(SRC_ADDR, 3'd5, JMP_NEXT);
      6'd21: w = uw_hex(SRC_ADDR, 3'd6, JMP_NEXT);
      6'd22: w = uw_hex(SRC_ADDR, 3'd7, JMP_NEXT);
      6'd23: w = uw_hex(SRC_DATA_H, 3'd0, JMP_NEXT);
      6'd24: w = uw_hex(SRC_DATA_L, 3'd0, JMP_DATA);
      6'd25: w = uw_hex(SRC_SUM_H, 3'd0, JMP_NEXT);
      6'd26: w = uw_hex(SRC_SUM_L, 3'd0, JMP_NEXT);
      6'd27: w = uw_lit(7'h0A, JMP_REC_END);
      6'd28: w = uw_lit(7'("S"), JMP_NEXT);
      6'd29: w = uw_lit(7'("7"), JMP_NEXT);
      6'd30: w = uw_lit(7'("0"), JMP_NEXT);
      6'd31: w = uw_lit(7'("5"), JMP_NEXT);
      6'd32: w = uw_lit(7'("0"), JMP_NEXT);
      6'd33: w = uw_lit(7'("0"), JMP_NEXT);
      6'd34: w = uw_lit(7'("0"), JMP_NEXT);
      6'd35: w = uw_lit(7'("0"), JMP_NEXT);
      6'd36: w = uw_lit(7'("0"), JMP_NEXT);
      6'd37: w = uw_lit(7'("0"), JMP_NEXT);
      6'd38: w = uw_lit(7'("0"), JMP_NEXT);
      6'd39: w = uw_lit(7'("0"), JMP_NEXT);
      6'd40: w = uw_lit(7'("F"), JMP_NEXT);
      6'd41: w = uw_lit(7'("A"), JMP_NEXT);
      6'd42: w = uw_lit(7'h0A, JMP_DONE);
      default: w = uw_lit(7'h0A, JMP_DONE);
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/srec_ifs.sv
// valid/ready channel interfaces of the s-record s3 encoder
`timescale 1ns / 1ps

interface srec_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  modport source(output valid, cmd, data_byte, input ready);
  modport sink(input valid, cmd, data_byte, output ready);
endinterface

interface srec_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       run_last;
  modport source(output valid, text_char, run_last, input ready);
  modport sink(input valid, text_char, run_last, output ready);
endinterface

interface srec_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_address;
  modport source(output valid, start_address, input ready);
  modport sink(input valid, start_address, output ready);
endinterface

// File: hw/rtl/srecord_s3_text_encoder.sv
// s-record s3 text encoder top level with microcoded character sequencer
`timescale 1ns / 1ps

// Turns a byte stream into Motorola S3 text, one ASCII character per output
// transfer. The first item of a transfer emits the S0 header and loads the
// record address from the start_address register; bytes collect until
// BYTES_PER_RECORD are held or the transfer ends, then an S3 record is
// emitted, and an end item adds the S7 trailer. An item that only buffers a
// byte is taken without holding the input. An item that produces text holds
// the input while it emits its characters (11 header, 15 + 2n for an n-byte
// record, 15 trailer, at most 62), because the sequencer steps through its
// program emitting one character per cycle into the output register, unless
// the output stalls. The output register decouples the sides, so the next
// item can be taken while the last character still waits. The configuration
// port never stalls; write it only between transfers.
module srecord_s3_text_encoder #(
  parameter int BYTES_PER_RECORD = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  srec_cfg_if.sink           cfg_ch,
  srec_in_if.sink            in_ch,
  srec_out_if.source         out_ch
);

  localparam int CNT_W = $clog2(BYTES_PER_RECORD + 1);
  localparam int IDX_W = (BYTES_PER_RECORD > 1) ? $clog2(BYTES_PER_RECORD) : 1;

  logic [srec_pkg::ADDR_W-1:0] cfg_addr_r;
  logic [srec_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]                  buf_r [BYTES_PER_RECORD];
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  logic                        hdr_done_r, hdr_done_nxt;
  logic [IDX_W-1:0]            bidx_r, bidx_nxt;
  logic                        busy_r, busy_nxt;
  logic [srec_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic                        do_rec_r, do_rec_nxt;
  logic                        do_end_r, do_end_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [6:0]                  out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_xfer;
  logic                        adv;
  logic                        hdr;
  logic                        has_byte;
  logic                        ends;
  logic [CNT_W-1:0]            base_cnt;
  logic [CNT_W-1:0]            new_cnt;
  logic                        buf_we;
  logic [IDX_W-1:0]            buf_widx;
  srec_pkg::uword_t            uw;
  logic [7:0]                  len_byte;
  logic [7:0]                  chk_byte;
  logic [7:0]                  data_sel;
  logic [3:0]                  addr_nib;
  logic [3:0]                  hex_nib;
  logic                        more_data;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !busy_r;
  assign in_xfer      = in_ch.valid && !busy_r;
  assign adv          = busy_r && (!out_valid_r || out_ch.ready);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.text_char = out_char_r;
  assign out_ch.run_last  = out_last_r;

  // accept side: fold the item into the buffered record
  assign hdr      = !hdr_done_r;
  assign has_byte = (in_ch.cmd == srec_pkg::CMD_DATA) || (in_ch.cmd == srec_pkg::CMD_LAST);
  assign ends     = (in_ch.cmd != srec_pkg::CMD_DATA);
  assign base_cnt = hdr ? '0 : cnt_r;
  assign new_cnt  = base_cnt + CNT_W'(has_byte);
  assign buf_we   = in_xfer && has_byte;
  assign buf_widx = base_cnt[IDX_W-1:0];

  // datapath feeding the character mux
  assign uw        = srec_pkg::ucode(pc_r);
  assign len_byte  = srec_pkg::LEN_BASE + 8'(cnt_r);
  assign chk_byte  = ~(sum_r + len_byte + addr_r[31:24] + addr_r[23:16]
                       + addr_r[15:8] + addr_r[7:0]);
  assign data_sel  = buf_r[bidx_r];
  assign addr_nib  = 4'(addr_r >> (5'd28 - {uw.nib, 2'b00}));
  assign more_data = (CNT_W'(bidx_r) + CNT_W'(1)) < cnt_r;

  always_comb begin
    unique case (uw.src)
      srec_pkg::SRC_LEN_H:  hex_nib = len_byte[7:4];
      srec_pkg::SRC_LEN_L:  hex_nib = len_byte[3:0];
      srec_pkg::SRC_ADDR:   hex_nib = addr_nib;
      srec_pkg::SRC_DATA_H: hex_nib = data_sel[7:4];
      srec_pkg::SRC_DATA_L: hex_nib = data_sel[3:0];
      srec_pkg::SRC_SUM_H:  hex_nib = chk_byte[7:4];
      srec_pkg::SRC_SUM_L:  hex_nib = chk_byte[3:0];
      srec_pkg::SRC_LIT:    hex_nib = 4'd0;
      default:              hex_nib = 4'd0;
    endcase
  end

  always_comb begin
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    hdr_done_nxt  = hdr_done_r;
    bidx_nxt      = bidx_r;
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    do_rec_nxt    = do_rec_r;
    do_end_nxt    = do_end_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (in_xfer) begin
      if (hdr) begin
        addr_nxt = cfg_addr_r;
      end
      cnt_nxt      = new_cnt;
      sum_nxt      = (hdr ? 8'd0 : sum_r) + (has_byte ? in_ch.data_byte : 8'd0);
      hdr_done_nxt = !ends;
      do_end_nxt   = ends;
      do_rec_nxt   = ((new_cnt == CNT_W'(BYTES_PER_RECORD)) || ends) && (new_cnt != '0);
      busy_nxt     = hdr || do_rec_nxt || ends;
      priority if (hdr) begin
        pc_nxt = srec_pkg::PC_HDR;
      end else if (do_rec_nxt) begin
        pc_nxt = srec_pkg::PC_REC;
      end else begin
        pc_nxt = srec_pkg::PC_END;
      end
    end

    if (adv) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = (uw.src == srec_pkg::SRC_LIT) ? uw.ch : srec_pkg::hex_char(hex_nib);
      out_last_nxt  = 1'b0;
      pc_nxt        = pc_r + srec_pkg::PC_W'(1);
      unique case (uw.jmp)
        srec_pkg::JMP_NEXT: begin
        end
        srec_pkg::JMP_HDR_END: begin
          priority if (do_rec_r) begin
            pc_nxt = srec_pkg::PC_REC;
          end else if (do_end_r) begin
            pc_nxt = srec_pkg::PC_END;
          end else begin
            busy_nxt     = 1'b0;
            out_last_nxt = 1'b1;
          end
        end
        srec_pkg::JMP_DATA: begin
          if (more_data) begin
            pc_nxt   = srec_pkg::PC_DATA_H;
            bidx_nxt = bidx_r + IDX_W'(1);
          end
        end
        srec_pkg::JMP_REC_END: begin
          // record is out: advance the load address and empty the buffer
          addr_nxt = addr_r + srec_pkg::ADDR_W'(cnt_r);
          cnt_nxt  = '0;
          sum_nxt  = 8'd0;
          bidx_nxt = '0;
          if (do_end_r) begin
            pc_nxt = srec_pkg::PC_END;
          end else begin
            busy_nxt     = 1'b0;
            out_last_nxt = 1'b1;
          end
        end
        srec_pkg::JMP_DONE: begin
          busy_nxt     = 1'b0;
          out_last_nxt = 1'b1;
        end
        default: begin
          busy_nxt     = 1'b0;
          out_last_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_addr_r  <= '0;
      cnt_r       <= '0;
      sum_r       <= 8'd0;
      hdr_done_r  <= 1'b0;
      bidx_r      <= '0;
      busy_r      <= 1'b0;
      pc_r        <= srec_pkg::PC_HDR;
      do_rec_r    <= 1'b0;
      do_end_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cfg_addr_r <= cfg_ch.start_address;
      end
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      hdr_done_r  <= hdr_done_nxt;
      bidx_r      <= bidx_nxt;
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      do_rec_r    <= do_rec_nxt;
      do_end_r    <= do_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (buf_we) begin
      buf_r[buf_widx] <= in_ch.data_byte;
    end
  end

endmodule

// File: hw/rtl/srec_checker.sv
// port-level checker for the s-record s3 encoder and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] text_char,
  input logic       run_last
);

  // a stalled character holds its payload
  `SREC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(run_last), "stalled output changed")

  // every run of text closes on a newline
  `SREC_ASSERT(a_last_newline, clk, rst_n, out_valid && run_last |-> text_char == 7'h0A, "run ends without newline")

  // no new item is taken while a run is still being emitted
  `SREC_ASSERT(a_no_accept_mid_run, clk, rst_n, out_valid && !run_last |-> !in_ready, "input ready inside a run")

  // nothing leaves the block right after reset
  `SREC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind srecord_s3_text_encoder srec_checker u_srec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .text_char (out_ch.text_char),
  .run_last  (out_ch.run_last)
);
